// File: sv/sste_pkg.sv
package sste_pkg;

  localparam int unsigned ADDR_BITS_DEF = 27;

  localparam int unsigned OFFSET_W = 27;
  localparam int unsigned BYTES_W  = 28;
  localparam int unsigned HALF_W   = 16;
  localparam int unsigned BUS_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned MEMSZ_W  = 28;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 120;

  localparam logic [MEMSZ_W-1:0] MEM_SIZE_RST = 28'd33554432;
  localparam logic [BUS_W-1:0]   BASE_RST     = 32'hC000_0000;

  localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_WDONE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RDATA  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CANCEL = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READY  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ARG   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_STATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_VERIFY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd6;

  localparam logic [0:0] CFG_MEM_SIZE = 1'b0;
  localparam logic [0:0] CFG_BASE     = 1'b1;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_LOAD,
    CUR_REWIND,
    CUR_STEP
  } cursor_cmd_t;

  function automatic logic [HALF_W-1:0] pattern_value(input logic [BUS_W-1:0] x,
                                                      input logic [1:0] pass);
    logic [HALF_W-1:0] v;
    v = pass[1] ? x[31:16] : x[15:0];
    return pass[0] ? ~v : v;
  endfunction

  function automatic logic [HALF_W-1:0] walking_value(input logic [3:0] bit_idx,
                                                      input logic inverted);
    logic [HALF_W-1:0] v;
    v = HALF_W'(1) << bit_idx;
    return inverted ? ~v : v;
  endfunction

endpackage

// File: sv/sdram_self_test_engine_unit.sv
// Channel | Dir | Handshake         | Payload
// in_     | in  | in_tvalid/tready  | tuser: action; tdata: start_offset, test_bytes, read_data
// out_    | out | out_tvalid/tready | tuser: kind; tdata: address .. fail_phase
// cfg_    | in  | cfg_valid/ready   | cfg_index, cfg_data
// An item is registered on entry and its result is then registered in the output register.
// One item per cycle while out_tready is high; the step logic sits between the two registers.
// A stalled result holds; the input register still takes one item while it waits.
// Reset (rst_n low at a clock edge) clears the test state and restores the config registers.
module sdram_self_test_engine_unit #(
  parameter int unsigned ADDR_BITS = sste_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action[2:0]
  input  logic [sste_pkg::ACTION_W-1:0]    in_tuser,
  // start_offset[26:0], test_bytes[54:27], read_data[70:55], zero pad[71]
  input  logic [sste_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // kind[1:0]
  output logic [sste_pkg::KIND_W-1:0]      out_tuser,
  // address[31:0], write_data[47:32], status[50:48], fail_offset[77:51],
  // fail_expected[93:78], fail_actual[109:94], fail_phase[112:110], zero pad[119:113]
  output logic [sste_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [sste_pkg::BUS_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    STG_WALK,
    STG_FILL,
    STG_CHECK
  } stage_t;

  logic [sste_pkg::MEMSZ_W-1:0] mem_size_r;
  logic [sste_pkg::BUS_W-1:0]   base_r;

  logic                          item_valid_r, item_valid_nxt;
  logic [sste_pkg::ACTION_W-1:0] act_r;
  logic [sste_pkg::OFFSET_W-1:0] off_r;
  logic [sste_pkg::BYTES_W-1:0]  bytes_r;
  logic [sste_pkg::HALF_W-1:0]   data_r;

  logic                          ready_r, ready_nxt;
  logic                          busy_r, busy_nxt;
  stage_t                        stage_r, stage_nxt;
  logic [3:0]                    walk_bit_r, walk_bit_nxt;
  logic                          walk_inv_r, walk_inv_nxt;
  logic [1:0]                    pass_r, pass_nxt;
  logic [sste_pkg::HALF_W-1:0]   exp_r, exp_nxt;
  logic                          await_r, await_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [sste_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [sste_pkg::BUS_W-1:0]    addr_r, addr_nxt;
  logic [sste_pkg::HALF_W-1:0]   wdata_r, wdata_nxt;
  logic [sste_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [sste_pkg::OFFSET_W-1:0] foff_r, foff_nxt;
  logic [sste_pkg::HALF_W-1:0]   fexp_r, fexp_nxt;
  logic [sste_pkg::HALF_W-1:0]   fact_r, fact_nxt;
  logic [sste_pkg::PHASE_W-1:0]  fphase_r, fphase_nxt;

  logic                          fire;
  logic                          expects_read;
  logic                          is_req;
  logic [sste_pkg::OFFSET_W-1:0] count;
  logic [sste_pkg::MEMSZ_W-1:0]  room;

  sste_pkg::cursor_cmd_t         cmd;
  logic                          more;
  logic [sste_pkg::BUS_W-1:0]    boff_nxt;
  logic [ADDR_BITS-1:0]          x_nxt;
  logic [sste_pkg::BUS_W-1:0]    boff_cur;
  logic [sste_pkg::BUS_W-1:0]    rs32;
  logic [sste_pkg::BUS_W-1:0]    x32;

  sste_cursor #(
    .ADDR_BITS(ADDR_BITS)
  ) u_cursor (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .ld_offset    (ADDR_BITS'(off_r)),
    .ld_count     (ADDR_BITS'(count)),
    .more         (more),
    .boff_nxt     (boff_nxt),
    .x_nxt        (x_nxt),
    .boff_cur     (boff_cur),
    .region_start (rs32)
  );

  assign fire      = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || fire;
  assign cfg_ready = 1'b1;

  assign count        = bytes_r[sste_pkg::BYTES_W-1:1];
  assign room         = mem_size_r - sste_pkg::MEMSZ_W'(off_r);
  assign x32          = sste_pkg::BUS_W'(x_nxt);
  assign expects_read = (stage_r == STG_CHECK) || ((stage_r == STG_WALK) && await_r);

  always_comb begin
    ready_nxt    = ready_r;
    busy_nxt     = busy_r;
    stage_nxt    = stage_r;
    walk_bit_nxt = walk_bit_r;
    walk_inv_nxt = walk_inv_r;
    pass_nxt     = pass_r;
    exp_nxt      = exp_r;
    await_nxt    = await_r;
    cmd          = sste_pkg::CUR_HOLD;
    is_req       = 1'b0;
    kind_nxt     = sste_pkg::KIND_ACK;
    wdata_nxt    = '0;
    status_nxt   = sste_pkg::ST_OK;
    foff_nxt     = '0;
    fexp_nxt     = '0;
    fact_nxt     = '0;
    fphase_nxt   = '0;

    if (fire) begin
      unique case (act_r)
        sste_pkg::ACT_START: begin
          if (busy_r) begin
            status_nxt = sste_pkg::ST_BUSY;
          end else if (bytes_r[0] || (bytes_r < sste_pkg::BYTES_W'(2))) begin
            kind_nxt   = sste_pkg::KIND_DONE;
            status_nxt = sste_pkg::ST_BAD_ARG;
          end else if (!ready_r) begin
            kind_nxt   = sste_pkg::KIND_DONE;
            status_nxt = sste_pkg::ST_BAD_STATE;
          end else if (off_r[0]) begin
            kind_nxt   = sste_pkg::KIND_DONE;
            status_nxt = sste_pkg::ST_BAD_ARG;
          end else if ((sste_pkg::MEMSZ_W'(off_r) > mem_size_r) ||
                       (count > room[sste_pkg::MEMSZ_W-1:1])) begin
            kind_nxt   = sste_pkg::KIND_DONE;
            status_nxt = sste_pkg::ST_RANGE;
          end else begin
            busy_nxt     = 1'b1;
            stage_nxt    = STG_WALK;
            walk_bit_nxt = '0;
            walk_inv_nxt = 1'b0;
            pass_nxt     = '0;
            await_nxt    = 1'b0;
            cmd          = sste_pkg::CUR_LOAD;
            exp_nxt      = sste_pkg::walking_value(4'd0, 1'b0);
            kind_nxt     = sste_pkg::KIND_WRITE;
            wdata_nxt    = exp_nxt;
            is_req       = 1'b1;
          end
        end
        sste_pkg::ACT_WDONE: begin
          if (!busy_r || expects_read) begin
            status_nxt = sste_pkg::ST_BAD_STATE;
          end else if (stage_r == STG_WALK) begin
            await_nxt = 1'b1;
            kind_nxt  = sste_pkg::KIND_READ;
            is_req    = 1'b1;
          end else if (more) begin
            cmd       = sste_pkg::CUR_STEP;
            exp_nxt   = sste_pkg::pattern_value(x32, pass_r);
            kind_nxt  = sste_pkg::KIND_WRITE;
            wdata_nxt = exp_nxt;
            is_req    = 1'b1;
          end else begin
            cmd       = sste_pkg::CUR_REWIND;
            stage_nxt = STG_CHECK;
            exp_nxt   = sste_pkg::pattern_value(x32, pass_r);
            kind_nxt  = sste_pkg::KIND_READ;
            is_req    = 1'b1;
          end
        end
        sste_pkg::ACT_RDATA: begin
          if (!busy_r || !expects_read) begin
            status_nxt = sste_pkg::ST_BAD_STATE;
          end else if (data_r != exp_r) begin
            kind_nxt   = sste_pkg::KIND_DONE;
            status_nxt = sste_pkg::ST_VERIFY;
            if (stage_r == STG_WALK) begin
              foff_nxt   = rs32[sste_pkg::OFFSET_W-1:0];
              fphase_nxt = '0;
            end else begin
              foff_nxt   = boff_cur[sste_pkg::OFFSET_W-1:0];
              fphase_nxt = sste_pkg::PHASE_W'(pass_r) + sste_pkg::PHASE_W'(1);
            end
            fexp_nxt  = exp_r;
            fact_nxt  = data_r;
            ready_nxt = 1'b0;
            busy_nxt  = 1'b0;
            await_nxt = 1'b0;
          end else if (stage_r == STG_WALK) begin
            await_nxt = 1'b0;
            if ((walk_bit_r == 4'd15) && walk_inv_r) begin
              walk_bit_nxt = '0;
              walk_inv_nxt = 1'b0;
              pass_nxt     = '0;
              stage_nxt    = STG_FILL;
              cmd          = sste_pkg::CUR_REWIND;
              exp_nxt      = sste_pkg::pattern_value(x32, 2'd0);
            end else begin
              if (!walk_inv_r) begin
                walk_inv_nxt = 1'b1;
              end else begin
                walk_inv_nxt = 1'b0;
                walk_bit_nxt = walk_bit_r + 4'd1;
              end
              exp_nxt = sste_pkg::walking_value(walk_bit_nxt, walk_inv_nxt);
            end
            kind_nxt  = sste_pkg::KIND_WRITE;
            wdata_nxt = exp_nxt;
            is_req    = 1'b1;
          end else if (more) begin
            cmd      = sste_pkg::CUR_STEP;
            exp_nxt  = sste_pkg::pattern_value(x32, pass_r);
            kind_nxt = sste_pkg::KIND_READ;
            is_req   = 1'b1;
          end else if (pass_r == 2'd3) begin
            busy_nxt  = 1'b0;
            stage_nxt = STG_WALK;
            kind_nxt  = sste_pkg::KIND_DONE;
          end else begin
            pass_nxt  = pass_r + 2'd1;
            stage_nxt = STG_FILL;
            cmd       = sste_pkg::CUR_REWIND;
            exp_nxt   = sste_pkg::pattern_value(x32, pass_nxt);
            kind_nxt  = sste_pkg::KIND_WRITE;
            wdata_nxt = exp_nxt;
            is_req    = 1'b1;
          end
        end
        sste_pkg::ACT_CANCEL: begin
          if (!busy_r) begin
            status_nxt = sste_pkg::ST_BAD_STATE;
          end else begin
            busy_nxt   = 1'b0;
            await_nxt  = 1'b0;
            stage_nxt  = STG_WALK;
            kind_nxt   = sste_pkg::KIND_DONE;
            status_nxt = sste_pkg::ST_CANCELLED;
          end
        end
        sste_pkg::ACT_READY: begin
          ready_nxt = 1'b1;
        end
        default: begin
          status_nxt = sste_pkg::ST_BAD_ARG;
        end
      endcase
    end

    addr_nxt = is_req ? (base_r + boff_nxt) : '0;
  end

  always_comb begin
    if (in_tvalid && in_tready) begin
      item_valid_nxt = 1'b1;
    end else if (fire) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= sste_pkg::MEM_SIZE_RST;
      base_r     <= sste_pkg::BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sste_pkg::CFG_MEM_SIZE: mem_size_r <= cfg_data[sste_pkg::MEMSZ_W-1:0];
        sste_pkg::CFG_BASE:     base_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r   <= in_tuser;
      off_r   <= in_tdata[26:0];
      bytes_r <= in_tdata[54:27];
      data_r  <= in_tdata[70:55];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      ready_r      <= 1'b0;
      busy_r       <= 1'b0;
      stage_r      <= STG_WALK;
      walk_bit_r   <= '0;
      walk_inv_r   <= 1'b0;
      pass_r       <= '0;
      exp_r        <= '0;
      await_r      <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      ready_r      <= ready_nxt;
      busy_r       <= busy_nxt;
      stage_r      <= stage_nxt;
      walk_bit_r   <= walk_bit_nxt;
      walk_inv_r   <= walk_inv_nxt;
      pass_r       <= pass_nxt;
      exp_r        <= exp_nxt;
      await_r      <= await_nxt;
    end
    if (fire) begin
      kind_r   <= kind_nxt;
      addr_r   <= addr_nxt;
      wdata_r  <= wdata_nxt;
      status_r <= status_nxt;
      foff_r   <= foff_nxt;
      fexp_r   <= fexp_nxt;
      fact_r   <= fact_nxt;
      fphase_r <= fphase_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {7'd0, fphase_r, fact_r, fexp_r, foff_r, status_r, wdata_r, addr_r};

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !await_r)
    else $error("read awaited while no test runs");

  a_read_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (stage_r == STG_WALK))
    else $error("walking read flag set outside the walking stage");

  a_req_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((kind_r == sste_pkg::KIND_WRITE) || (kind_r == sste_pkg::KIND_READ)))
      |-> busy_r)
    else $error("memory request shown while no test runs");

  a_fail_clears_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == sste_pkg::ST_VERIFY)) |-> (!ready_r && !busy_r))
    else $error("verify failure left the device ready or the test busy");

endmodule

// File: sv/sste_cursor.sv
module sste_cursor #(
  parameter int unsigned ADDR_BITS = sste_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sste_pkg::cursor_cmd_t       cmd,
  input  logic [ADDR_BITS-1:0]        ld_offset,
  input  logic [ADDR_BITS-1:0]        ld_count,
  output logic                        more,
  output logic [sste_pkg::BUS_W-1:0]  boff_nxt,
  output logic [ADDR_BITS-1:0]        x_nxt,
  output logic [sste_pkg::BUS_W-1:0]  boff_cur,
  output logic [sste_pkg::BUS_W-1:0]  region_start
);

  logic [ADDR_BITS-1:0]       hc_r, hc_nxt;
  logic [ADDR_BITS-1:0]       rs_r, rs_nxt;
  logic [ADDR_BITS-1:0]       rh_r, rh_nxt;
  logic [ADDR_BITS-1:0]       x_r;
  logic [sste_pkg::BUS_W-1:0] boff_r;
  logic [ADDR_BITS-1:0]       hc_inc;

  assign hc_inc       = hc_r + 1'b1;
  assign more         = hc_inc < rh_r;
  assign boff_cur     = boff_r;
  assign region_start = sste_pkg::BUS_W'(rs_r);

  always_comb begin
    hc_nxt   = hc_r;
    rs_nxt   = rs_r;
    rh_nxt   = rh_r;
    x_nxt    = x_r;
    boff_nxt = boff_r;
    unique case (cmd)
      sste_pkg::CUR_HOLD: begin
      end
      sste_pkg::CUR_LOAD: begin
        hc_nxt   = '0;
        rs_nxt   = ld_offset;
        rh_nxt   = ld_count;
        x_nxt    = ld_offset >> 1;
        boff_nxt = sste_pkg::BUS_W'(ld_offset);
      end
      sste_pkg::CUR_REWIND: begin
        hc_nxt   = '0;
        x_nxt    = rs_r >> 1;
        boff_nxt = sste_pkg::BUS_W'(rs_r);
      end
      sste_pkg::CUR_STEP: begin
        hc_nxt   = hc_inc;
        x_nxt    = x_r + 1'b1;
        boff_nxt = boff_r + sste_pkg::BUS_W'(2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r   <= '0;
      rs_r   <= '0;
      rh_r   <= '0;
      x_r    <= '0;
      boff_r <= '0;
    end else begin
      hc_r   <= hc_nxt;
      rs_r   <= rs_nxt;
      rh_r   <= rh_nxt;
      x_r    <= x_nxt;
      boff_r <= boff_nxt;
    end
  end

endmodule
